### hdl/stt_pkg.sv
package stt_pkg;

	localparam int STT_KEYWORD_CHARS = 8;
	localparam int STT_LINE_BITS     = 16;
	localparam int STT_LENGTH_BITS   = 8;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} stt_in_t;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] line_number;
		logic [7:0]  lexeme_length;
		logic        last_of_run;
	} stt_tok_t;

	localparam logic [4:0] K_IDENT   = 5'd0;
	localparam logic [4:0] K_ICONST  = 5'd1;
	localparam logic [4:0] K_RCONST  = 5'd2;
	localparam logic [4:0] K_SCONST  = 5'd3;
	localparam logic [4:0] K_BCONST  = 5'd4;
	localparam logic [4:0] K_PLUS    = 5'd5;
	localparam logic [4:0] K_MINUS   = 5'd6;
	localparam logic [4:0] K_MULT    = 5'd7;
	localparam logic [4:0] K_DIV     = 5'd8;
	localparam logic [4:0] K_ASSOP   = 5'd9;
	localparam logic [4:0] K_EQUAL   = 5'd10;
	localparam logic [4:0] K_GTHAN   = 5'd11;
	localparam logic [4:0] K_LTHAN   = 5'd12;
	localparam logic [4:0] K_AND     = 5'd13;
	localparam logic [4:0] K_OR      = 5'd14;
	localparam logic [4:0] K_NOT     = 5'd15;
	localparam logic [4:0] K_COMMA   = 5'd16;
	localparam logic [4:0] K_LPAREN  = 5'd17;
	localparam logic [4:0] K_RPAREN  = 5'd18;
	localparam logic [4:0] K_SEMICOL = 5'd19;
	localparam logic [4:0] K_ERR     = 5'd20;
	localparam logic [4:0] K_DONE    = 5'd21;
	localparam logic [4:0] K_PROGRAM = 5'd22;
	localparam logic [4:0] K_PRINT   = 5'd23;
	localparam logic [4:0] K_INT     = 5'd24;
	localparam logic [4:0] K_END     = 5'd25;
	localparam logic [4:0] K_FLOAT   = 5'd26;
	localparam logic [4:0] K_BOOL    = 5'd27;
	localparam logic [4:0] K_ELSE    = 5'd28;
	localparam logic [4:0] K_IF      = 5'd29;
	localparam logic [4:0] K_THEN    = 5'd30;

	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NOT    = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5a;
	localparam logic [7:0] CH_UNDER  = 8'h5f;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7a;
	localparam logic [7:0] CH_BAR    = 8'h7c;

	localparam int KW_COUNT = 11;

	localparam logic [0:KW_COUNT-1][55:0] KW_TEXT = {
		"PROGRAM", "PRINT  ", "INT    ", "END    ", "FLOAT  ", "BOOL   ",
		"ELSE   ", "IF     ", "THEN   ", "TRUE   ", "FALSE  "
	};
	localparam logic [0:KW_COUNT-1][2:0] KW_LEN = {
		3'd7, 3'd5, 3'd3, 3'd3, 3'd5, 3'd4, 3'd4, 3'd2, 3'd4, 3'd4, 3'd5
	};
	localparam logic [0:KW_COUNT-1][4:0] KW_KIND = {
		K_PROGRAM, K_PRINT, K_INT, K_END, K_FLOAT, K_BOOL,
		K_ELSE, K_IF, K_THEN, K_BCONST, K_BCONST
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) ? c - 8'h20 : c;
	endfunction

	// ch holds the first seven upper-cased characters, first one in the top byte
	function automatic logic [4:0] kw_kind(input logic [55:0] ch, input logic [2:0] n);
		logic [4:0] k;
		logic       hit;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = (KW_LEN[i] == n);
			for (int j = 0; j < 7; j++) begin
				if ((3'(j) < KW_LEN[i]) && (ch[55-8*j -: 8] != KW_TEXT[i][55-8*j -: 8]))
					hit = 1'b0;
			end
			if (hit)
				k = KW_KIND[i];
		end
		return k;
	endfunction

endpackage

### hdl/source_text_tokenizer.sv
// channel  | valid / ready         | payload                     | transfer
// ---------+-----------------------+-----------------------------+---------------------------
// source   | src_valid / src_ready | src_data  (stt_in_t)        | one character or end mark
// tokens   | tok_valid / tok_ready | tok_data  (stt_tok_t)       | one token
//
// One character is scanned per cycle; its zero, one or two tokens enter a
// four-entry result queue in the same cycle and leave it one per cycle.
// src_ready is high while the queue has at least two free entries.
// Reset clears the scanner state and the queue; the keyword buffer is not reset.
// A stall on the token side fills the queue and then holds src_ready low.
module source_text_tokenizer #(
	parameter int KEYWORD_CHARS = stt_pkg::STT_KEYWORD_CHARS,
	parameter int LINE_BITS     = stt_pkg::STT_LINE_BITS,
	parameter int LENGTH_BITS   = stt_pkg::STT_LENGTH_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  stt_pkg::stt_in_t  src_data,
	output logic              tok_valid,
	input  logic              tok_ready,
	output stt_pkg::stt_tok_t tok_data
);
	import stt_pkg::*;

	localparam logic [2:0] M_START   = 3'd0;
	localparam logic [2:0] M_IDENT   = 3'd1;
	localparam logic [2:0] M_INT     = 3'd2;
	localparam logic [2:0] M_REAL    = 3'd3;
	localparam logic [2:0] M_STRING  = 3'd4;
	localparam logic [2:0] M_COMMENT = 3'd5;

	localparam int KW_IDX_BITS = $clog2(KEYWORD_CHARS);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;

	logic [2:0]             mode_q;
	logic                   dot_q;
	logic [7:0]             held_q;
	logic                   hv_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [7:0]             kw_q [KEYWORD_CHARS];

	stt_tok_t               que_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wptr_q;
	logic [QPTR_BITS-1:0]   rptr_q;
	logic [QPTR_BITS:0]     cnt_q;

	logic       take;
	logic       pop;
	logic [7:0] c;
	logic       eoi;

	function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] x);
		return (x == LEN_MAX) ? x : x + 1'b1;
	endfunction

	assign take = src_valid && src_ready;
	assign pop  = tok_valid && tok_ready;
	assign c    = src_data.char_code;
	assign eoi  = src_data.end_of_input;

	// identifier kind from the buffered characters
	logic [55:0] kw_chars;
	logic [4:0]  ident_kind;

	always_comb begin
		for (int j = 0; j < 7; j++)
			kw_chars[55-8*j -: 8] = kw_q[j];
		ident_kind = (len_q < LENGTH_BITS'(8)) ? kw_kind(kw_chars, len_q[2:0]) : K_IDENT;
	end

	// start of a new token from c
	logic [2:0]             sc_mode;
	logic                   sc_hold;
	logic                   sc_set_len;
	logic [LENGTH_BITS-1:0] sc_len;
	logic                   sc_kw;
	logic                   sc_emit;
	logic [4:0]             sc_kind;

	always_comb begin
		sc_mode    = M_START;
		sc_hold    = 1'b0;
		sc_set_len = 1'b0;
		sc_len     = '0;
		sc_kw      = 1'b0;
		sc_emit    = 1'b0;
		sc_kind    = K_ERR;
		if (is_space(c)) begin
			sc_mode = M_START;
		end else if (is_alpha(c) || (c == CH_UNDER)) begin
			sc_mode    = M_IDENT;
			sc_set_len = 1'b1;
			sc_len     = LENGTH_BITS'(1);
			sc_kw      = 1'b1;
		end else if (is_digit(c)) begin
			sc_mode    = M_INT;
			sc_set_len = 1'b1;
			sc_len     = LENGTH_BITS'(1);
		end else if (c == CH_QUOTE) begin
			sc_mode    = M_STRING;
			sc_set_len = 1'b1;
		end else begin
			case (c) inside
				CH_SLASH, CH_AMP, CH_BAR, CH_EQ: sc_hold = 1'b1;
				CH_PLUS:   begin sc_emit = 1'b1; sc_kind = K_PLUS;    end
				CH_MINUS:  begin sc_emit = 1'b1; sc_kind = K_MINUS;   end
				CH_STAR:   begin sc_emit = 1'b1; sc_kind = K_MULT;    end
				CH_GT:     begin sc_emit = 1'b1; sc_kind = K_GTHAN;   end
				CH_LT:     begin sc_emit = 1'b1; sc_kind = K_LTHAN;   end
				CH_NOT:    begin sc_emit = 1'b1; sc_kind = K_NOT;     end
				CH_LPAREN: begin sc_emit = 1'b1; sc_kind = K_LPAREN;  end
				CH_RPAREN: begin sc_emit = 1'b1; sc_kind = K_RPAREN;  end
				CH_SEMI:   begin sc_emit = 1'b1; sc_kind = K_SEMICOL; end
				CH_COMMA:  begin sc_emit = 1'b1; sc_kind = K_COMMA;   end
				CH_DOT, CH_DOLLAR: begin sc_emit = 1'b1; sc_kind = K_ERR; end
				default: sc_emit = 1'b0;
			endcase
		end
	end

	// scanner step
	logic [2:0]                n_mode;
	logic                      n_dot;
	logic [7:0]                n_held;
	logic                      n_hv;
	logic [LINE_BITS-1:0]      n_line;
	logic [LENGTH_BITS-1:0]    n_len;
	logic                      kw_we;
	logic [KW_IDX_BITS-1:0]    kw_wa;
	logic [7:0]                kw_wd;
	logic                      a_v;
	logic [4:0]                a_k;
	logic [LENGTH_BITS-1:0]    a_l;
	logic                      b_v;
	logic [4:0]                b_k;
	logic [LENGTH_BITS-1:0]    b_l;

	always_comb begin
		logic call_sc;
		logic nl;
		call_sc = 1'b0;
		nl      = 1'b0;
		n_mode  = mode_q;
		n_dot   = dot_q;
		n_held  = held_q;
		n_hv    = hv_q;
		n_len   = len_q;
		n_line  = line_q;
		kw_we   = 1'b0;
		kw_wa   = len_q[KW_IDX_BITS-1:0];
		kw_wd   = to_upper(c);
		a_v     = 1'b0;
		a_k     = K_ERR;
		a_l     = len_q;
		b_v     = 1'b0;
		b_k     = K_DONE;
		b_l     = '0;
		if (eoi) begin
			case (mode_q)
				M_START: begin
					if (hv_q) begin
						a_v = 1'b1;
						a_l = LENGTH_BITS'(1);
						if (held_q == CH_SLASH)
							a_k = K_DIV;
						else if ((held_q == CH_AMP) || (held_q == CH_BAR))
							a_k = K_ERR;
						else
							a_k = K_ASSOP;
					end
				end
				M_IDENT: begin a_v = 1'b1; a_k = ident_kind; end
				M_INT:   begin a_v = 1'b1; a_k = K_ICONST; end
				M_REAL: begin
					a_v = 1'b1;
					if (hv_q) begin
						a_k = K_ERR;
						a_l = len_inc(len_q);
					end else begin
						a_k = K_RCONST;
					end
				end
				M_STRING: begin a_v = 1'b1; a_k = K_ERR; a_l = len_inc(len_q); end
				default: a_v = 1'b0;
			endcase
			b_v    = 1'b1;
			n_mode = M_START;
			n_dot  = 1'b0;
			n_held = '0;
			n_hv   = 1'b0;
			n_len  = '0;
			n_line = '0;
		end else begin
			case (mode_q)
				M_START: begin
					if (!hv_q) begin
						call_sc = 1'b1;
					end else begin
						n_hv = 1'b0;
						if (held_q == CH_SLASH) begin
							if (c == CH_STAR) begin
								n_mode = M_COMMENT;
							end else begin
								a_v = 1'b1; a_k = K_DIV; a_l = LENGTH_BITS'(1);
								call_sc = 1'b1;
							end
						end else if ((held_q == CH_AMP) || (held_q == CH_BAR)) begin
							a_v = 1'b1;
							if (c == held_q) begin
								a_k = (held_q == CH_AMP) ? K_AND : K_OR;
								a_l = LENGTH_BITS'(2);
							end else begin
								a_k = K_ERR; a_l = LENGTH_BITS'(1);
								call_sc = 1'b1;
							end
						end else begin
							a_v = 1'b1;
							if (c == CH_EQ) begin
								a_k = K_EQUAL; a_l = LENGTH_BITS'(2);
							end else begin
								a_k = K_ASSOP; a_l = LENGTH_BITS'(1);
								call_sc = 1'b1;
							end
						end
					end
				end
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_AT)) begin
						kw_we = (32'(len_q) < KEYWORD_CHARS);
						n_len = len_inc(len_q);
					end else begin
						a_v = 1'b1; a_k = ident_kind;
						call_sc = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						n_len = len_inc(len_q);
					end else if (c == CH_DOT) begin
						n_mode = M_REAL;
						n_dot  = 1'b0;
						n_held = c;
						n_hv   = 1'b1;
					end else begin
						a_v = 1'b1; a_k = K_ICONST;
						call_sc = 1'b1;
					end
				end
				M_REAL: begin
					if (hv_q) begin
						n_hv = 1'b0;
						if (is_digit(c) && !dot_q) begin
							n_dot = 1'b1;
							n_len = len_inc(len_inc(len_q));
						end else begin
							a_v = 1'b1; a_k = K_ERR; a_l = len_inc(len_q);
							call_sc = 1'b1;
						end
					end else if (is_digit(c)) begin
						n_len = len_inc(len_q);
					end else if (c == CH_DOT) begin
						n_held = c;
						n_hv   = 1'b1;
					end else begin
						a_v = 1'b1; a_k = K_RCONST;
						call_sc = 1'b1;
					end
				end
				M_STRING: begin
					if (c == CH_NL) begin
						a_v = 1'b1; a_k = K_ERR; a_l = len_inc(len_q);
						nl = 1'b1;
						n_mode = M_START;
					end else if (c == CH_QUOTE) begin
						a_v = 1'b1; a_k = K_SCONST;
						n_mode = M_START;
					end else begin
						n_len = len_inc(len_q);
					end
				end
				M_COMMENT: begin
					if (hv_q && (c == CH_SLASH)) begin
						n_hv   = 1'b0;
						n_mode = M_START;
					end else begin
						n_hv = (c == CH_STAR);
						if (c == CH_STAR)
							n_held = c;
						nl = (c == CH_NL);
					end
				end
				default: call_sc = 1'b1;
			endcase
			if (call_sc) begin
				n_mode = sc_mode;
				n_hv   = sc_hold;
				n_dot  = 1'b0;
				nl     = (c == CH_NL);
				if (sc_hold)
					n_held = c;
				if (sc_set_len)
					n_len = sc_len;
				if (sc_kw) begin
					kw_we = 1'b1;
					kw_wa = '0;
				end
				b_v = sc_emit;
				b_k = sc_kind;
				b_l = LENGTH_BITS'(1);
			end
			if (nl && (line_q != LINE_MAX))
				n_line = line_q + 1'b1;
		end
	end

	// results of this step, packed to the front
	stt_tok_t p0;
	stt_tok_t p1;
	logic     p1_v;
	logic     p0_v;

	always_comb begin
		p0_v = a_v || b_v;
		p1_v = a_v && b_v;
		p0.token_kind    = a_v ? a_k : b_k;
		p0.line_number   = 16'(line_q);
		p0.lexeme_length = 8'(a_v ? a_l : b_l);
		p0.last_of_run   = !p1_v;
		p1.token_kind    = b_k;
		p1.line_number   = 16'(line_q);
		p1.lexeme_length = 8'(b_l);
		p1.last_of_run   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			dot_q  <= 1'b0;
			held_q <= '0;
			hv_q   <= 1'b0;
			line_q <= '0;
			len_q  <= '0;
		end else if (take) begin
			mode_q <= n_mode;
			dot_q  <= n_dot;
			held_q <= n_held;
			hv_q   <= n_hv;
			line_q <= n_line;
			len_q  <= n_len;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !eoi && kw_we)
			kw_q[kw_wa] <= kw_wd;
	end

	// result queue
	logic [1:0] npush;

	assign npush = take ? ({1'b0, p0_v} + {1'b0, p1_v}) : 2'd0;

	always_ff @(posedge clk) begin
		if (take && p0_v)
			que_q[wptr_q] <= p0;
		if (take && p1_v)
			que_q[wptr_q + 1'b1] <= p1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + QPTR_BITS'(npush);
			if (pop)
				rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(npush) - (QPTR_BITS+1)'(pop);
		end
	end

	assign src_ready = (cnt_q <= (QPTR_BITS+1)'(QDEPTH - 2));
	assign tok_valid = (cnt_q != '0);
	assign tok_data  = que_q[rptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_BITS+1)'(QDEPTH))
		else $error("result queue count out of range");

	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> cnt_q <= (QPTR_BITS+1)'(QDEPTH))
		else $error("result queue overrun");

	a_eoi_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take && eoi |=> (mode_q == M_START) && !hv_q && (len_q == '0) && (line_q == '0))
		else $error("scanner state not cleared after end of input");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && (tok_data.token_kind == K_DONE) |-> tok_data.last_of_run)
		else $error("DONE token not marked last");

	a_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDENT) || (mode_q == M_INT) || (mode_q == M_STRING) |-> !hv_q)
		else $error("held character in a mode that never holds one");

endmodule
